@@ rtl/srs_pkg.sv @@
`timescale 1ns / 1ps

package srs_pkg;

    localparam int MAX_STAGES_DEF = 8;

    localparam int STAGE_W = 3;
    localparam int COUNT_W = 8;
    localparam int CFG_W   = 64;
    localparam int CFG_IDX_W = 2;
    localparam int SCNT_W  = 4;

    typedef enum logic [1:0] {
        OUT_COMPLETE  = 2'd0,
        OUT_REEXECUTE = 2'd1,
        OUT_ABORT     = 2'd2,
        OUT_OTHER     = 2'd3
    } t_outcome;

    localparam logic [CFG_IDX_W-1:0] CFG_STAGE_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STAGE_LIMITS = 2'd1;

    typedef struct packed {
        logic [STAGE_W-1:0] ran_stage;
        logic               ran;
        logic [STAGE_W-1:0] next_stage;
        logic               restarted;
        logic               at_start;
    } t_result;

endpackage

@@ rtl/srs_step.sv @@
`timescale 1ns / 1ps

module srs_step #(
    parameter int MAX_STAGES = srs_pkg::MAX_STAGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [srs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [srs_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_accept,
    input  logic [1:0]                    i_outcome,
    output srs_pkg::t_result              o_result
);
    import srs_pkg::*;

    localparam int IDX_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam logic [SCNT_W-1:0] MAX_CNT = SCNT_W'(MAX_STAGES);

    logic [SCNT_W-1:0]  r_stage_count;
    logic [CFG_W-1:0]   r_stage_limits;
    logic [STAGE_W-1:0] r_cur, n_cur;
    logic [COUNT_W-1:0] r_used [MAX_STAGES];
    logic [COUNT_W-1:0] n_used_cur;
    logic               wr_used;

    logic [SCNT_W-1:0]  eff_count;
    logic [SCNT_W-1:0]  adv_sum;
    logic [STAGE_W-1:0] adv_idx;
    logic [COUNT_W-1:0] limit;
    logic [COUNT_W-1:0] used_cur;
    logic [COUNT_W:0]   used_inc;
    logic               ran;
    logic               restarted;
    logic [COUNT_W-1:0] used0_next;
    logic [IDX_W-1:0]   cur_i;

    assign cur_i    = r_cur[IDX_W-1:0];
    assign limit    = r_stage_limits[r_cur*COUNT_W +: COUNT_W];
    assign used_cur = r_used[cur_i];
    assign used_inc = {1'b0, used_cur} + 1'b1;

    always_comb begin
        if (r_stage_count == '0) begin
            eff_count = SCNT_W'(1);
        end else if (r_stage_count > MAX_CNT) begin
            eff_count = MAX_CNT;
        end else begin
            eff_count = r_stage_count;
        end
        adv_sum = {1'b0, r_cur} + 1'b1;
        adv_idx = (adv_sum >= eff_count) ? '0 : adv_sum[STAGE_W-1:0];
    end

    always_comb begin
        n_cur      = r_cur;
        n_used_cur = used_cur;
        wr_used    = 1'b0;
        ran        = 1'b0;
        restarted  = 1'b0;
        if (limit == '0) begin
            n_cur = adv_idx;
        end else begin
            ran = 1'b1;
            case (t_outcome'(i_outcome))
                OUT_COMPLETE: begin
                    n_used_cur = '0;
                    wr_used    = 1'b1;
                    n_cur      = adv_idx;
                end
                OUT_REEXECUTE: begin
                    wr_used = 1'b1;
                    if (used_inc < {1'b0, limit}) begin
                        n_used_cur = used_inc[COUNT_W-1:0];
                    end else begin
                        // retries used up, same as abort
                        n_used_cur = '0;
                        n_cur      = '0;
                        restarted  = 1'b1;
                    end
                end
                OUT_ABORT: begin
                    n_used_cur = '0;
                    wr_used    = 1'b1;
                    n_cur      = '0;
                    restarted  = 1'b1;
                end
                default: begin
                end
            endcase
        end
        used0_next = (wr_used && r_cur == '0) ? n_used_cur : r_used[0];
    end

    assign o_result.ran_stage  = r_cur;
    assign o_result.ran        = ran;
    assign o_result.next_stage = n_cur;
    assign o_result.restarted  = restarted;
    assign o_result.at_start   = (n_cur == '0) && (used0_next == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_count  <= SCNT_W'(1);
            r_stage_limits <= '0;
            r_cur          <= '0;
            for (int k = 0; k < MAX_STAGES; k++) begin
                r_used[k] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_STAGE_COUNT: begin
                    r_stage_count <= i_cfg_data[SCNT_W-1:0];
                    for (int k = 0; k < MAX_STAGES; k++) begin
                        r_used[k] <= '0;
                    end
                end
                CFG_STAGE_LIMITS: begin
                    r_stage_limits <= i_cfg_data;
                    for (int k = 0; k < MAX_STAGES; k++) begin
                        r_used[k] <= '0;
                    end
                end
                default: begin
                end
            endcase
        end else if (i_accept) begin
            r_cur <= n_cur;
            if (wr_used) begin
                r_used[cur_i] <= n_used_cur;
            end
        end
    end

endmodule

@@ rtl/srs_skid.sv @@
`timescale 1ns / 1ps

module srs_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  srs_pkg::t_result i_result,
    input  logic             i_out_stall,
    output logic             o_full,
    output logic             o_out_valid,
    output srs_pkg::t_result o_result
);
    import srs_pkg::*;

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    logic    out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            // skid word goes first, a new word cannot arrive while it is held
            r_out_valid  <= r_skid_valid || i_accept;
            r_skid_valid <= 1'b0;
        end else if (i_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_result;
        end else if (i_accept) begin
            r_skid <= i_result;
        end
    end

endmodule

@@ rtl/staged_retry_sequencer_top.sv @@
`timescale 1ns / 1ps
// output: each accepted outcome word yields a registered result word, held in the skid word while the output stalls
// throughput: one outcome per cycle while o_in_stall is low, set by the single counter
// read-modify-write on the per-stage used counts; a two-word output buffer keeps
// accepting while one result waits
// reset: synchronous active low; stage 0, all used counts zero, stage count 1, all stage limits zero

module staged_retry_sequencer_top #(
    parameter int MAX_STAGES = srs_pkg::MAX_STAGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [srs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [srs_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_outcome,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [srs_pkg::STAGE_W-1:0]   o_ran_stage,
    output logic                          o_ran,
    output logic [srs_pkg::STAGE_W-1:0]   o_next_stage,
    output logic                          o_restarted,
    output logic                          o_at_start
);
    import srs_pkg::*;

    logic    accept;
    t_result step_res;
    t_result out_res;

    assign accept = i_in_valid && !o_in_stall;

    srs_step #(
        .MAX_STAGES(MAX_STAGES)
    ) u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_outcome  (i_outcome),
        .o_result   (step_res)
    );

    srs_skid u_skid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_result   (step_res),
        .i_out_stall(i_out_stall),
        .o_full     (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_result   (out_res)
    );

    assign o_ran_stage  = out_res.ran_stage;
    assign o_ran        = out_res.ran;
    assign o_next_stage = out_res.next_stage;
    assign o_restarted  = out_res.restarted;
    assign o_at_start   = out_res.at_start;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("skid word held without an output word");

    a_restart_to_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_restarted) |-> (o_ran && o_next_stage == '0))
        else $error("restart without a handled stage or not at stage 0");

    a_start_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_at_start) |-> (o_next_stage == '0))
        else $error("at_start flagged away from stage 0");

    a_accept_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted word produced no result");

endmodule
